/* rtl/bdch_pkg.sv */
// Shared types and constants for the button debouncer with click and hold events
`timescale 1ns / 1ps
package bdch_pkg;

  localparam int TICK_WIDTH_DEF = 32;
  localparam int CFG_WIDTH = 16;
  localparam int ADDR_WIDTH = 4;

  typedef enum logic [2:0] {
    EV_DOWN  = 3'd0,
    EV_UP    = 3'd1,
    EV_CLICK = 3'd2,
    EV_LONG  = 3'd3,
    EV_HOLD  = 3'd4
  } event_code_e;

  typedef enum logic [1:0] {
    REG_BUTTON_ID  = 2'd0,
    REG_DEBOUNCE   = 2'd1,
    REG_LONG_CLICK = 2'd2,
    REG_HOLD       = 2'd3
  } reg_index_e;

  localparam logic [CFG_WIDTH-1:0] BUTTON_ID_RST  = 16'd0;
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [CFG_WIDTH-1:0] LONG_CLICK_RST = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] HOLD_RST       = 16'd1500;

endpackage

/* rtl/button_debounce_click_hold.sv */
// Top level: button debouncer with down, up, click, long click and hold events
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_ready_o   pin_level_i
//   out      source     out_valid_o / out_ready_i event_code_o, source_id_o,
//                                                 is_pressed_o, last_event_o
//   cfg      APB slave  psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One tick is folded into the state in the cycle it is accepted; its 0 to 3
// event words are loaded into a three-entry result buffer and leave one word
// per cycle while out_ready_i is high.
// A new tick is taken once the buffer holds at most its final word being taken.
// Reset clears the tick counter, pressed, pending and hold flags and the buffer.
// A stalled output holds the buffer and blocks further ticks.
`timescale 1ns / 1ps
module button_debounce_click_hold
  import bdch_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  pin_level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            event_code_o,
  output logic [CFG_WIDTH-1:0]  source_id_o,
  output logic                  is_pressed_o,
  output logic                  last_event_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [CFG_WIDTH-1:0] button_id_q, debounce_q, long_click_q, hold_q;

  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic                  pressed_q, pressed_d;
  logic                  pending_q, pending_d;
  logic                  hold_fired_q, hold_fired_d;
  logic [TICK_WIDTH-1:0] change_start_q, change_start_d;
  logic [TICK_WIDTH-1:0] press_start_q, press_start_d;

  event_code_e           ev_q [3];
  event_code_e           ev_d [3];
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            n_ev;
  logic [1:0]            base;
  logic                  out_pressed_q;
  logic [CFG_WIDTH-1:0]  id_q;

  logic                  in_fire, out_fire, cfg_wr;
  logic                  level_pressed, start_change, hold_hit, expire, long_press;
  logic [TICK_WIDTH-1:0] el_press, el_change;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_id_q  <= BUTTON_ID_RST;
      debounce_q   <= DEBOUNCE_RST;
      long_click_q <= LONG_CLICK_RST;
      hold_q       <= HOLD_RST;
    end else if (cfg_wr) begin
      unique case (reg_index_e'(paddr[3:2]))
        REG_BUTTON_ID:  button_id_q  <= pwdata[CFG_WIDTH-1:0];
        REG_DEBOUNCE:   debounce_q   <= pwdata[CFG_WIDTH-1:0];
        REG_LONG_CLICK: long_click_q <= pwdata[CFG_WIDTH-1:0];
        REG_HOLD:       hold_q       <= pwdata[CFG_WIDTH-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_e'(paddr[3:2]))
      REG_BUTTON_ID:  prdata = 32'(button_id_q);
      REG_DEBOUNCE:   prdata = 32'(debounce_q);
      REG_LONG_CLICK: prdata = 32'(long_click_q);
      REG_HOLD:       prdata = 32'(hold_q);
      default:        prdata = '0;
    endcase
  end

  // handshakes
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_ready_i);
  assign in_fire     = in_valid_i & in_ready_o;

  // one tick of state update
  assign level_pressed = ~pin_level_i;
  assign tick_d        = tick_q + TICK_WIDTH'(1);
  assign start_change  = (level_pressed != pressed_q) & ~pending_q;
  assign change_start_d = start_change ? tick_d : change_start_q;
  assign el_press      = tick_d - press_start_q;
  assign el_change     = tick_d - change_start_d;
  assign hold_hit      = pressed_q & ~hold_fired_q & (el_press >= TICK_WIDTH'(hold_q));
  assign expire        = (pending_q | start_change) & (el_change > TICK_WIDTH'(debounce_q));
  assign long_press    = (el_press >= TICK_WIDTH'(long_click_q));

  assign pending_d     = (pending_q | start_change) & ~expire;
  assign pressed_d     = expire ? level_pressed : pressed_q;
  assign hold_fired_d  = expire ? 1'b0 : (hold_fired_q | hold_hit);
  assign press_start_d = (expire & level_pressed) ? tick_d : press_start_q;

  always_comb begin
    ev_d = '{EV_DOWN, EV_DOWN, EV_DOWN};
    base = hold_hit ? 2'd1 : 2'd0;
    n_ev = base;
    if (hold_hit) begin
      ev_d[0] = EV_HOLD;
    end
    if (expire) begin
      if (level_pressed) begin
        ev_d[base] = EV_DOWN;
        n_ev       = base + 2'd1;
      end else begin
        ev_d[base]        = EV_UP;
        ev_d[base + 2'd1] = long_press ? EV_LONG : EV_CLICK;
        n_ev              = base + 2'd2;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = n_ev;
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q         <= '0;
      pressed_q      <= 1'b0;
      pending_q      <= 1'b0;
      hold_fired_q   <= 1'b0;
      change_start_q <= '0;
      press_start_q  <= '0;
      cnt_q          <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        tick_q         <= tick_d;
        pressed_q      <= pressed_d;
        pending_q      <= pending_d;
        hold_fired_q   <= hold_fired_d;
        change_start_q <= change_start_d;
        press_start_q  <= press_start_d;
      end
    end
  end

  // result buffer, head at entry 0
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q          <= ev_d;
      out_pressed_q <= pressed_d;
      id_q          <= button_id_q;
    end else if (out_fire) begin
      ev_q[0] <= ev_q[1];
      ev_q[1] <= ev_q[2];
    end
  end

  assign event_code_o = ev_q[0];
  assign source_id_o  = id_q;
  assign is_pressed_o = out_pressed_q;
  assign last_event_o = (cnt_q == 2'd1);

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_event_o && !in_fire) |=> !out_valid_o)
    else $error("buffer not empty after final word");

  a_up_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((event_code_o == EV_UP) || (event_code_o == EV_CLICK)
      || (event_code_o == EV_LONG))) |-> !is_pressed_o)
    else $error("release word while pressed");

  a_down_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_code_o == EV_DOWN)) |-> is_pressed_o)
    else $error("down word while released");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the button debouncer: ticks in, checked event words out, APB setup
module tb_top;
  import bdch_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL = 120;
  localparam int DRAIN_CYCLES = 6;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    event_code_e           code;
    logic [CFG_WIDTH-1:0]  id;
    logic                  pressed;
    logic                  last;
  } event_word_t;

  typedef struct {
    logic        pin;
    int          n_typed;
    event_code_e first;
  } tick_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  pin_level_i = 1'b1;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            event_code_o;
  logic [CFG_WIDTH-1:0]  source_id_o;
  logic                  is_pressed_o;
  logic                  last_event_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // predictor state and register copies
  logic [TICK_WIDTH_DEF-1:0] tick_cnt = '0;
  logic [TICK_WIDTH_DEF-1:0] change_at = '0;
  logic [TICK_WIDTH_DEF-1:0] press_at = '0;
  logic                      pressed_q = 1'b0;
  logic                      pending_q = 1'b0;
  logic                      hold_done = 1'b0;
  logic [CFG_WIDTH-1:0]      id_cfg = BUTTON_ID_RST;
  logic [CFG_WIDTH-1:0]      deb_cfg = DEBOUNCE_RST;
  logic [CFG_WIDTH-1:0]      long_cfg = LONG_CLICK_RST;
  logic [CFG_WIDTH-1:0]      hold_cfg = HOLD_RST;

  event_word_t events_due[$];
  event_word_t head_word;
  int          errors = 0;
  int          cycles = 0;
  int          ticks_sent = 0;
  int          snd_pct = 0;
  int          rcv_pct = 0;
  bit          long_stall_due = 1'b0;

  // debounce 0, long click 3, hold 2; -1 leaves the row to the predictor alone
  tick_row_t directed_ticks[23] = '{
    '{1'b1, 0, EV_DOWN}, '{1'b0, 0, EV_DOWN}, '{1'b0, 1, EV_DOWN}, '{1'b0, 0, EV_DOWN},
    '{1'b0, 1, EV_HOLD}, '{1'b1, 0, EV_DOWN}, '{1'b1, 2, EV_UP},   '{1'b0, 0, EV_DOWN},
    '{1'b1, -1, EV_UP},  '{1'b0, 0, EV_DOWN}, '{1'b0, 1, EV_DOWN}, '{1'b1, 0, EV_DOWN},
    '{1'b1, 3, EV_HOLD}, '{1'b0, 0, EV_DOWN}, '{1'b1, -1, EV_UP},  '{1'b0, 0, EV_DOWN},
    '{1'b0, 1, EV_DOWN}, '{1'b1, 0, EV_DOWN}, '{1'b0, -1, EV_HOLD}, '{1'b0, 0, EV_DOWN},
    '{1'b0, 1, EV_HOLD}, '{1'b1, 0, EV_DOWN}, '{1'b1, 2, EV_UP}
  };

  button_debounce_click_hold DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pin_level_i  (pin_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .source_id_o  (source_id_o),
    .is_pressed_o (is_pressed_o),
    .last_event_o (last_event_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void fold_tick(input logic pin, output int n, output event_code_e first);
    event_code_e codes[3];
    logic        lvl_pressed;
    event_word_t w;
    n = 0;
    first = EV_DOWN;
    lvl_pressed = !pin;
    tick_cnt = tick_cnt + 1'b1;
    if (lvl_pressed != pressed_q && !pending_q) begin
      pending_q = 1'b1;
      change_at = tick_cnt;
    end
    if (pressed_q && !hold_done && tick_cnt - press_at >= hold_cfg) begin
      hold_done = 1'b1;
      codes[n] = EV_HOLD;
      n++;
    end
    if (pending_q && tick_cnt - change_at > deb_cfg) begin
      pending_q = 1'b0;
      hold_done = 1'b0;
      pressed_q = lvl_pressed;
      if (pressed_q) begin
        codes[n] = EV_DOWN;
        n++;
        press_at = tick_cnt;
      end else begin
        codes[n] = EV_UP;
        n++;
        codes[n] = (tick_cnt - press_at >= long_cfg) ? EV_LONG : EV_CLICK;
        n++;
      end
    end
    if (n > 0) first = codes[0];
    for (int k = 0; k < n; k++) begin
      w.code = codes[k];
      w.id = id_cfg;
      w.pressed = pressed_q;
      w.last = (k == n - 1);
      events_due.push_back(w);
    end
  endfunction

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_stall_due) begin
        long_stall_due = 1'b0;
        repeat (LONG_STALL) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready_i <= ($urandom_range(99) >= rcv_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual code %0d id %h pressed %b last %b",
                 $time, event_code_o, source_id_o, is_pressed_o, last_event_o);
      end else begin
        head_word = events_due.pop_front();
        if (event_code_o !== head_word.code || source_id_o !== head_word.id ||
            is_pressed_o !== head_word.pressed || last_event_o !== head_word.last) begin
          errors++;
          $display("%0t: word mismatch: expected code %0d id %h pressed %b last %b, %s",
                   $time, head_word.code, head_word.id, head_word.pressed, head_word.last,
                   $sformatf("actual code %0d id %h pressed %b last %b", event_code_o,
                             source_id_o, is_pressed_o, last_event_o));
        end
      end
    end
  end

  task automatic apb_access(input bit is_write, input reg_index_e idx,
                            input logic [CFG_WIDTH-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (is_write) begin
      case (idx)
        REG_BUTTON_ID:  id_cfg = val;
        REG_DEBOUNCE:   deb_cfg = val;
        REG_LONG_CLICK: long_cfg = val;
        REG_HOLD:       hold_cfg = val;
        default: ;
      endcase
    end else if (prdata !== {16'b0, val}) begin
      errors++;
      $display("%0t: register %0d read: expected %h, actual %h", $time, idx, {16'b0, val}, prdata);
    end
  endtask

  task automatic program_regs(input logic [CFG_WIDTH-1:0] id, input logic [CFG_WIDTH-1:0] deb,
                              input logic [CFG_WIDTH-1:0] lng, input logic [CFG_WIDTH-1:0] hld);
    apb_access(1'b1, REG_BUTTON_ID, id);
    apb_access(1'b1, REG_DEBOUNCE, deb);
    apb_access(1'b1, REG_LONG_CLICK, lng);
    apb_access(1'b1, REG_HOLD, hld);
    apb_access(1'b0, REG_BUTTON_ID, id_cfg);
    apb_access(1'b0, REG_DEBOUNCE, deb_cfg);
    apb_access(1'b0, REG_LONG_CLICK, long_cfg);
    apb_access(1'b0, REG_HOLD, hold_cfg);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_tick(input logic pin, output int n, output event_code_e first);
    idle_e mode;
    mode = idle_e'((ticks_sent / 25) % 4);
    snd_pct = (mode == IDLE_SEND) ? 57 : (mode == IDLE_BOTH) ? 29 : 0;
    rcv_pct = (mode == IDLE_RECV) ? 57 : (mode == IDLE_BOTH) ? 29 : 0;
    while ($urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_level_i <= pin;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
    fold_tick(pin, n, first);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // level runs of random length, with the odd one-tick glitch
  task automatic play_runs(input int count, input int max_run);
    logic        lvl;
    logic        pin;
    int          run_len;
    int          n;
    event_code_e first;
    lvl = !pressed_q;
    while (count > 0) begin
      run_len = $urandom_range(max_run, 1);
      for (int k = 0; k < run_len && count > 0; k++) begin
        pin = ($urandom_range(99) < 12) ? !lvl : lvl;
        send_tick(pin, n, first);
        count--;
      end
      lvl = !lvl;
    end
  endtask

  initial begin
    int          n;
    event_code_e first;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(16'hFFFF, 16'd0, 16'd3, 16'd2);
    foreach (directed_ticks[i]) begin
      send_tick(directed_ticks[i].pin, n, first);
      if (directed_ticks[i].n_typed >= 0 &&
          (n != directed_ticks[i].n_typed || (n > 0 && first != directed_ticks[i].first))) begin
        errors++;
        $display("%0t: tick %0d: expected %0d words first %0d, actual %0d words first %0d",
                 $time, i, directed_ticks[i].n_typed, directed_ticks[i].first, n, first);
      end
    end

    wait_drained();
    program_regs(16'($urandom), DEBOUNCE_RST, LONG_CLICK_RST, HOLD_RST);
    play_runs(40, 25);

    wait_drained();
    program_regs(16'd0, 16'd0, 16'd0, 16'd0);
    play_runs(80, 4);

    wait_drained();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    play_runs(15, 8);

    wait_drained();
    program_regs(16'($urandom), 16'($urandom_range(3)), 16'($urandom_range(20, 1)),
                 16'($urandom_range(25, 1)));
    play_runs(120, 30);

    wait_drained();
    program_regs(16'($urandom), 16'($urandom_range(6)), 16'($urandom_range(40)),
                 16'($urandom_range(40)));
    long_stall_due = 1'b1;
    play_runs(65, 30);
    wait_drained();
    play_runs(65, 30);
    wait_drained();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bdch_pkg.sv
rtl/button_debounce_click_hold.sv
verif/tb_top.sv
